// ===== rtl/core/pwrt_pkg.sv =====
`timescale 1ns / 1ps

package pwrt_pkg;

  localparam int MaxRules = 16;
  localparam int TagBits = 16;
  localparam int TypeBits = 8;
  localparam int QueueBits = 31;
  localparam int NumTags = 6;
  localparam int IdxBits = $clog2(MaxRules);
  localparam int CntBits = $clog2(MaxRules + 1);

  typedef enum logic [1:0] {
    ACT_INSTALL = 2'd0,
    ACT_REMOVE  = 2'd1,
    ACT_LOOKUP  = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOMATCH  = 3'd4
  } status_t;

  typedef struct packed {
    logic [QueueBits-1:0] queue;
    logic [TypeBits-1:0]  rtype;
    logic [2:0]           level;
    logic [NumTags-1:0][TagBits-1:0] tags;
  } rule_t;

  typedef struct packed {
    logic          rd_en;
    logic [IdxBits-1:0] rd_addr;
    logic          wr_en;
    logic [IdxBits-1:0] wr_addr;
    rule_t         wr_data;
  } mem_ctl_t;

endpackage

// ===== rtl/core/pwrt_mem.sv =====
`timescale 1ns / 1ps

module pwrt_mem
  import pwrt_pkg::*;
(
  input  logic     clk,
  input  mem_ctl_t ctl,
  output rule_t    rd_data
);

  rule_t mem [MaxRules];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

endmodule

// ===== rtl/core/pwrt_ctrl.sv =====
`timescale 1ns / 1ps

module pwrt_ctrl
  import pwrt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           action,
  input  logic [QueueBits-1:0] queue_id,
  input  logic [TypeBits-1:0]  type_id,
  input  logic [5:0]           ns_mask,
  input  logic [NumTags-1:0][TagBits-1:0] req_tags,
  output mem_ctl_t             mctl,
  input  rule_t                rd_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           status,
  output logic [QueueBits-1:0] matched_queue,
  output logic [CntBits-1:0]   count
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_CHECK = 6'b000100,
    S_SHIFT = 6'b001000,
    S_PUT   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  logic [1:0] act;
  rule_t rule;
  logic [NumTags-1:0][TagBits-1:0] req;
  logic [CntBits-1:0] idx;
  logic [CntBits-1:0] pos;
  logic pos_found;
  logic del_found;
  logic [CntBits-1:0] sh;
  logic [CntBits-1:0] sh_m1;

  logic [2:0] lvl;
  rule_t new_rule;
  logic same, hit;

  assign sh_m1 = sh - 1'b1;

  always_comb begin
    lvl = 3'd0;
    new_rule.queue = queue_id;
    new_rule.rtype = type_id;
    for (int t = 0; t < NumTags; t++) begin
      new_rule.tags[t] = ns_mask[t] ? req_tags[t] : '0;
      lvl = lvl + {2'd0, ns_mask[t]};
    end
    new_rule.level = lvl;
  end

  always_comb begin
    same = (rd_data.level == rule.level) && (rd_data.rtype == rule.rtype)
      && (rd_data.tags == rule.tags);
    hit = (rd_data.rtype == '0) || (rd_data.rtype == rule.rtype);
    for (int t = 0; t < NumTags; t++) begin
      if (rd_data.tags[t] != '0 && rd_data.tags[t] != req[t]) hit = 1'b0;
    end
  end

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    mctl = '0;
    case (state)
      S_READ: begin
        mctl.rd_en = 1'b1;
        mctl.rd_addr = idx[IdxBits-1:0];
      end
      S_SHIFT: begin
        mctl.rd_en = 1'b1;
        mctl.rd_addr = (act == ACT_INSTALL) ? sh_m1[IdxBits-1:0] : sh[IdxBits-1:0];
      end
      S_PUT: begin
        mctl.wr_en = 1'b1;
        mctl.wr_addr = (act == ACT_INSTALL) ? sh[IdxBits-1:0] : sh_m1[IdxBits-1:0];
        mctl.wr_data = (act == ACT_INSTALL && sh == pos) ? rule : rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      count <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            act <= action;
            rule <= new_rule;
            req <= req_tags;
            idx <= '0;
            pos <= count;
            sh <= count;
            pos_found <= 1'b0;
            del_found <= 1'b0;
            matched_queue <= '0;
            if (action == ACT_CLEAR) begin
              count <= '0;
              status <= ST_OK;
              state <= S_DONE;
            end else if (count == '0) begin
              status <= (action == ACT_INSTALL) ? ST_OK
                : (action == ACT_REMOVE) ? ST_NOTFOUND : ST_NOMATCH;
              if (action == ACT_INSTALL) state <= S_PUT;
              else state <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (act == ACT_LOOKUP && hit) begin
            status <= ST_OK;
            matched_queue <= rd_data.queue;
            state <= S_DONE;
          end else if (act != ACT_LOOKUP && same) begin
            if (act == ACT_INSTALL) begin
              status <= ST_DUP;
              state <= S_DONE;
            end else begin
              del_found <= 1'b1;
              status <= ST_OK;
              if (idx + 1'b1 == count) begin
                count <= count - 1'b1;
                state <= S_DONE;
              end else begin
                sh <= idx + 1'b1;
                state <= S_SHIFT;
              end
            end
          end else begin
            if (act == ACT_INSTALL && !pos_found && rd_data.level < rule.level) begin
              pos <= idx;
              pos_found <= 1'b1;
            end
            if (idx + 1'b1 == count) begin
              if (act == ACT_LOOKUP) status <= ST_NOMATCH;
              else if (act == ACT_REMOVE) status <= ST_NOTFOUND;
              else if (count == CntBits'(MaxRules)) status <= ST_FULL;
              else status <= ST_OK;
              if (act == ACT_INSTALL && count != CntBits'(MaxRules)) begin
                sh <= count;
                if (!pos_found && !(rd_data.level < rule.level)) state <= S_PUT;
                else state <= S_SHIFT;
              end else begin
                state <= S_DONE;
              end
            end else begin
              idx <= idx + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_SHIFT: begin
          state <= S_PUT;
        end
        S_PUT: begin
          if (act == ACT_INSTALL) begin
            if (sh == pos) begin
              count <= count + 1'b1;
              state <= S_DONE;
            end else begin
              sh <= sh_m1;
              if (sh_m1 == pos) state <= S_PUT;
              else state <= S_SHIFT;
            end
          end else begin
            if (sh + 1'b1 == count) begin
              count <= count - 1'b1;
              state <= S_DONE;
            end else begin
              sh <= sh + 1'b1;
              state <= S_SHIFT;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/priority_wildcard_rule_table_core.sv =====
// operation: each word walks the single-port rule memory, reading entries in turn
//   (read, then check) and moving shifted entries one by one (read, then write)
// throughput: one word at a time; a new word is taken once the previous result
//   has been accepted or is accepted in the same cycle
// reset: rst clears the rule count and control; rule memory keeps its contents
`timescale 1ns / 1ps

module priority_wildcard_rule_table_core
  import pwrt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           action,
  input  logic [QueueBits-1:0] queue_id,
  input  logic [TypeBits-1:0]  type_id,
  input  logic [5:0]           ns_mask,
  input  logic [TagBits-1:0]   uts_tag,
  input  logic [TagBits-1:0]   ipc_tag,
  input  logic [TagBits-1:0]   mnt_tag,
  input  logic [TagBits-1:0]   pid_tag,
  input  logic [TagBits-1:0]   net_tag,
  input  logic [TagBits-1:0]   cgroup_tag,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           status,
  output logic [QueueBits-1:0] matched_queue
);

  mem_ctl_t mctl;
  rule_t rd_data;
  logic [CntBits-1:0] count;
  logic [NumTags-1:0][TagBits-1:0] req_tags;

  assign req_tags = {cgroup_tag, net_tag, pid_tag, mnt_tag, ipc_tag, uts_tag};

  pwrt_mem u_mem (
    .clk(clk), .ctl(mctl), .rd_data(rd_data)
  );

  pwrt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .queue_id(queue_id), .type_id(type_id), .ns_mask(ns_mask),
    .req_tags(req_tags), .mctl(mctl), .rd_data(rd_data),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .matched_queue(matched_queue), .count(count)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntBits'(MaxRules)) else $error("rule count overflow");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !mctl.wr_en) else $error("memory write while idle");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pwrt_pkg::*;

  typedef struct packed {
    logic [1:0]           act;
    logic [QueueBits-1:0] queue;
    logic [TypeBits-1:0]  rtype;
    logic [5:0]           mask;
    logic [NumTags-1:0][TagBits-1:0] tags;
  } word_t;

  typedef struct packed {
    logic [2:0]           st;
    logic [QueueBits-1:0] mq;
  } reply_t;

  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = '0;
  logic [QueueBits-1:0] queue_id = '0;
  logic [TypeBits-1:0] type_id = '0;
  logic [5:0] ns_mask = '0;
  logic [TagBits-1:0] uts_tag = '0, ipc_tag = '0, mnt_tag = '0;
  logic [TagBits-1:0] pid_tag = '0, net_tag = '0, cgroup_tag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [QueueBits-1:0] matched_queue;

  always #4 clk = ~clk;

  priority_wildcard_rule_table_core u_top (.*);

  // shadow rule table
  rule_t tbl [MaxRules];
  int tbl_cnt;

  word_t pending_q[$];
  reply_t reply_q[$];
  int errors, n_sent, n_recv, idle_cnt;
  int n_hit, n_dup, n_full, n_nf;
  bit quiet, gen_done, hold_in;
  int in_gap, out_gap;

  function automatic reply_t classify(word_t w);
    rule_t r;
    reply_t res;
    int k, pos, hit;
    bit ok;
    r = '0;
    r.queue = w.queue;
    r.rtype = w.rtype;
    for (int t = 0; t < NumTags; t++)
      if (w.mask[t]) begin
        r.tags[t] = w.tags[t];
        r.level++;
      end
    res = '{st: ST_OK, mq: '0};
    hit = -1;
    if (w.act == ACT_INSTALL || w.act == ACT_REMOVE)
      for (k = 0; k < tbl_cnt; k++)
        if (tbl[k].level == r.level && tbl[k].rtype == r.rtype && tbl[k].tags == r.tags) begin
          hit = k;
          break;
        end
    case (w.act)
      ACT_INSTALL: begin
        if (hit >= 0) res.st = ST_DUP;
        else if (tbl_cnt >= MaxRules) res.st = ST_FULL;
        else begin
          pos = tbl_cnt;
          for (k = 0; k < tbl_cnt; k++)
            if (tbl[k].level < r.level) begin
              pos = k;
              break;
            end
          for (k = tbl_cnt; k > pos; k--) tbl[k] = tbl[k-1];
          tbl[pos] = r;
          tbl_cnt++;
        end
      end
      ACT_REMOVE: begin
        if (hit < 0) res.st = ST_NOTFOUND;
        else begin
          for (k = hit; k + 1 < tbl_cnt; k++) tbl[k] = tbl[k+1];
          tbl_cnt--;
        end
      end
      ACT_LOOKUP: begin
        res.st = ST_NOMATCH;
        for (k = 0; k < tbl_cnt; k++) begin
          ok = (tbl[k].rtype == 0) || (tbl[k].rtype == w.rtype);
          for (int t = 0; t < NumTags; t++)
            if (tbl[k].tags[t] != 0 && tbl[k].tags[t] != w.tags[t]) ok = 0;
          if (ok) begin
            res.st = ST_OK;
            res.mq = tbl[k].queue;
            break;
          end
        end
      end
      default: tbl_cnt = 0;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s at result %0d: got %0d want %0d", what, n_recv, got, want);
    errors++;
  endtask

  // small tag pool so lookups and duplicates hit often
  function automatic logic [TagBits-1:0] pick_tag();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return TagBits'($urandom_range(1, 3));
    if (r == 7) return '1;
    return TagBits'($urandom_range(1, 65535));
  endfunction

  function automatic word_t rand_word(bit rich);
    word_t w;
    w.act = 2'($urandom_range(0, 99) < 40 ? ACT_INSTALL :
                $urandom_range(0, 99) < 40 ? ACT_LOOKUP : ACT_REMOVE);
    if ($urandom_range(0, 99) < 2) w.act = ACT_CLEAR;
    w.queue = rich ? QueueBits'($urandom) : QueueBits'($urandom_range(0, 20));
    w.rtype = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2));
    w.mask = 6'($urandom);
    for (int t = 0; t < NumTags; t++) w.tags[t] = pick_tag();
    return w;
  endfunction

  function automatic word_t mk(action_t a, int q, int ty, int m, int tg);
    word_t w;
    w.act = a;
    w.queue = QueueBits'(q);
    w.rtype = TypeBits'(ty);
    w.mask = 6'(m);
    for (int t = 0; t < NumTags; t++) w.tags[t] = TagBits'(tg);
    return w;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    pending_q.push_back(mk(ACT_LOOKUP, 5, 1, 0, 1));
    pending_q.push_back(mk(ACT_REMOVE, 0, 1, 0, 1));
    pending_q.push_back(mk(ACT_INSTALL, 32'h7fffffff, 255, 63, 16'hffff));
    pending_q.push_back(mk(ACT_INSTALL, 0, 0, 0, 1));
    pending_q.push_back(mk(ACT_INSTALL, 9, 0, 0, 2));
    pending_q.push_back(mk(ACT_LOOKUP, 0, 255, 0, 16'hffff));
    pending_q.push_back(mk(ACT_LOOKUP, 0, 7, 0, 16'h1234));
    pending_q.push_back(mk(ACT_REMOVE, 0, 0, 0, 5));
    pending_q.push_back(mk(ACT_LOOKUP, 0, 7, 0, 1));
    pending_q.push_back(mk(ACT_INSTALL, 77, 3, 6'h15, 16'h0));
    pending_q.push_back(mk(ACT_LOOKUP, 0, 3, 0, 16'h55));
    pending_q.push_back(mk(ACT_CLEAR, 0, 0, 0, 0));
    pending_q.push_back(mk(ACT_LOOKUP, 0, 255, 0, 16'hffff));
    for (int i = 0; i < 17; i++)
      pending_q.push_back(mk(ACT_INSTALL, i + 1, i, 6'(i), i + 1));
    pending_q.push_back(mk(ACT_INSTALL, 3, 2, 2, 3));
    pending_q.push_back(mk(ACT_LOOKUP, 0, 4, 0, 5));
    for (int i = 0; i < 300; i++) pending_q.push_back(rand_word(i % 2));
    wait (pending_q.size() == 0);
    hold_in = 1'b1;
    wait (reply_q.size() == 0 && !in_valid);
    hold_in = 1'b0;
    for (int i = 0; i < 220; i++) pending_q.push_back(rand_word(1));
    wait (pending_q.size() < 60);
    quiet = 1'b1;
    gen_done = 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        n_sent++;
        reply_q.push_back(classify('{action, queue_id, type_id, ns_mask,
          {cgroup_tag, net_tag, pid_tag, mnt_tag, ipc_tag, uts_tag}}));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 19) == 0) begin
          in_gap = $urandom_range(1, 10);
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0 && !hold_in) begin
          word_t w;
          w = pending_q.pop_front();
          in_valid <= 1'b1;
          action <= w.act;
          queue_id <= w.queue;
          type_id <= w.rtype;
          ns_mask <= w.mask;
          {cgroup_tag, net_tag, pid_tag, mnt_tag, ipc_tag, uts_tag} <= w.tags;
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        reply_t e;
        if (reply_q.size() == 0) begin
          $display("unexpected result word status %0d", status);
          errors++;
        end else begin
          e = reply_q.pop_front();
          if (status != e.st) report_mismatch("status", status, e.st);
          if (matched_queue != e.mq) report_mismatch("matched_queue", matched_queue, e.mq);
          if (e.st == ST_OK && e.mq != 0) n_hit++;
          if (e.st == ST_DUP) n_dup++;
          if (e.st == ST_FULL) n_full++;
          if (e.st == ST_NOTFOUND) n_nf++;
        end
        n_recv++;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_gap = $urandom_range(1, 10);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WatchLimit) begin
        $display("timeout with %0d results outstanding", reply_q.size());
        $display("*** FAILED ***");
        $finish;
      end else if (gen_done && pending_q.size() == 0 && !in_valid && reply_q.size() == 0
                   && idle_cnt > 4 * MaxRules + 10) begin
        $display("ran %0d words, %0d results; hits %0d, duplicates %0d, full %0d, absent %0d",
                 n_sent, n_recv, n_hit, n_dup, n_full, n_nf);
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
